[rtl/kmsc_pkg.sv]
// ----------------------------------------------------------------------------
// kmsc_pkg
// Shared constants, types and codes for the k-mer sample count table.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsc_pkg;

    localparam int ENTRIES = 1024;
    localparam int SAMPLES = 8;

    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SIDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int NZ_W    = $clog2(SAMPLES + 1);
    localparam int CMP_W   = (NZ_W > 4) ? NZ_W : 4;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 32;
    localparam int ROW_W   = 1 + KEY_W + CNT_W * SAMPLES;

    localparam logic [AW:0] ENTRIES_V = (AW + 1)'(ENTRIES);
    localparam logic [8:0]  SAMPLES_V = 9'(SAMPLES);
    localparam logic [10:0] REMOVED_MAX = 11'd2047;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ADD   = 2'd2,
        ACT_SWEEP = 2'd3
    } t_action;

    typedef struct packed {
        logic                              valid;
        logic [KEY_W-1:0]                  key;
        logic [SAMPLES-1:0][CNT_W-1:0]     counts;
    } t_row;

    typedef struct packed {
        logic [10:0]      removed;
        logic             full_res;
        logic             hit;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

[rtl/kmsc_ram.sv]
// ----------------------------------------------------------------------------
// kmsc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsc_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/kmer_sample_count_table_core.sv]
// ----------------------------------------------------------------------------
// kmer_sample_count_table_core
// Associative k-mer table with one 32-bit count per sample, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one request per transaction:
//     tdata = action, key, sample, amount, min_samples from the lowest bit.
//   Master stream returns exactly one result per request:
//     tdata = count, hit, full_res, removed from the lowest bit.
//   Each table row (valid, key, all sample counts) sits in one RAM word.
//   Every request scans all ENTRIES rows through the RAM read port, one row
//   a cycle. Read, write and add load the result register in the update
//   state, where write and add also write back the selected row; a sweep
//   removes rows through the write port during the scan. The next request
//   is accepted in the cycle after the result enters the output register.
//   After reset the block clears the valid bit of every row before it
//   accepts a request.
//   A finished result waits in the output register while the next request
//   is accepted; if the receiver stalls, that next request holds at its end
//   until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_sample_count_table_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // action[1:0], key[65:2], sample[68:66], amount[100:69], min_samples[104:101]
    input  wire logic [kmsc_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // count[31:0], hit[32], full_res[33], removed[44:34]
    output logic [kmsc_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    import kmsc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_UPD   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [AW:0]      r_addr, n_addr;
    logic             r_dv, n_dv;
    logic [AW-1:0]    r_daddr;
    t_action          r_act;
    logic [KEY_W-1:0] r_key;
    logic [2:0]       r_sample;
    logic [CNT_W-1:0] r_amount;
    logic [3:0]       r_min;
    logic             r_hit, n_hit;
    logic [AW-1:0]    r_hslot;
    t_row             r_hrow;
    logic             r_free_ok, n_free_ok;
    logic [AW-1:0]    r_fslot;
    logic [10:0]      r_removed, n_removed;
    t_result          r_res;
    logic             r_ov;
    t_result          r_out;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    t_row             wrow, rrow, base_row;
    logic [ROW_W-1:0] rdata;
    logic [NZ_W-1:0]  nz;
    logic             sample_ok;
    logic [SIDX_W-1:0] sidx;
    logic [CNT_W-1:0] old_cnt, new_cnt;
    logic             out_free;

    kmsc_ram #(.W(ROW_W), .D(ENTRIES), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wrow),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rrow       = t_row'(rdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OUT_DATA_W'(r_out);
    assign out_free   = !r_ov || i_m_tready;
    assign sample_ok  = {6'd0, r_sample} < SAMPLES_V;
    assign sidx       = SIDX_W'(r_sample);

    always_comb begin
        nz = '0;
        for (int s = 0; s < SAMPLES; s++) begin
            nz = nz + NZ_W'(rrow.counts[s] != '0);
        end
    end

    always_comb begin
        base_row       = r_hrow;
        if (!r_hit) begin
            base_row.valid  = 1'b1;
            base_row.key    = r_key;
            base_row.counts = '0;
        end
        old_cnt = base_row.counts[sidx];
        new_cnt = (r_act == ACT_WRITE) ? r_amount : old_cnt + r_amount;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_dv      = 1'b0;
        n_hit     = r_hit;
        n_free_ok = r_free_ok;
        n_removed = r_removed;
        we        = 1'b0;
        waddr     = r_addr[AW-1:0];
        wrow      = '0;
        re        = 1'b0;
        raddr     = r_addr[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ENTRIES_V - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_addr    = '0;
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
                n_removed = '0;
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr != ENTRIES_V) begin
                    re     = 1'b1;
                    n_dv   = 1'b1;
                    n_addr = r_addr + 1'b1;
                end
                if (r_dv) begin
                    if (r_act == ACT_SWEEP) begin
                        if (rrow.valid && (CMP_W'(nz) < CMP_W'(r_min))) begin
                            we    = 1'b1;
                            waddr = r_daddr;
                            wrow  = rrow;
                            wrow.valid = 1'b0;
                            if (r_removed != REMOVED_MAX) begin
                                n_removed = r_removed + 1'b1;
                            end
                        end
                    end else begin
                        if (rrow.valid && rrow.key == r_key && !r_hit) begin
                            n_hit = 1'b1;
                        end
                        if (!rrow.valid && !r_free_ok) begin
                            n_free_ok = 1'b1;
                        end
                    end
                end
                if (r_addr == ENTRIES_V && !r_dv) begin
                    n_state = (r_act == ACT_SWEEP) ? S_FIN : S_UPD;
                end
            end
            S_UPD: begin
                if (r_act != ACT_READ && sample_ok && (r_hit || r_free_ok)) begin
                    we    = 1'b1;
                    waddr = r_hit ? r_hslot : r_fslot;
                    wrow  = base_row;
                    wrow.counts[sidx] = new_cnt;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dv    <= n_dv;
            if (r_state == S_FIN && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr   <= r_addr[AW-1:0];
        r_hit     <= n_hit;
        r_free_ok <= n_free_ok;
        r_removed <= n_removed;
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_act    <= t_action'(i_s_tdata[1:0]);
            r_key    <= i_s_tdata[65:2];
            r_sample <= i_s_tdata[68:66];
            r_amount <= i_s_tdata[100:69];
            r_min    <= i_s_tdata[104:101];
        end
        if (r_state == S_SCAN && r_dv) begin
            if (rrow.valid && rrow.key == r_key && !r_hit) begin
                r_hslot <= r_daddr;
                r_hrow  <= rrow;
            end
            if (!rrow.valid && !r_free_ok) begin
                r_fslot <= r_daddr;
            end
        end
        if (r_state == S_UPD) begin
            r_res.removed  <= '0;
            r_res.hit      <= r_hit;
            r_res.full_res <= (r_act != ACT_READ) && sample_ok && !r_hit && !r_free_ok;
            if (r_act == ACT_READ) begin
                r_res.count <= (r_hit && sample_ok) ? r_hrow.counts[sidx] : '0;
            end else begin
                r_res.count <= (sample_ok && (r_hit || r_free_ok)) ? new_cnt : '0;
            end
        end else if (r_state == S_SCAN && r_act == ACT_SWEEP) begin
            r_res <= t_result'({n_removed, 1'b0, 1'b0, {CNT_W{1'b0}}});
        end
        if (r_state == S_FIN && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire
